// ===== rtl/uvs_pkg.sv =====
// Package of shared types, constants and helpers for the UV-sphere vertex generator.
package uvs_pkg;

   localparam int MAX_BANDS    = 256;
   localparam int BAND_W       = 9;
   localparam int RADIUS_W     = 16;
   localparam int Q15_W        = 16;
   localparam int POS_W        = 24;
   localparam int INDEX_W      = 17;
   localparam int CSR_INDEX_W  = 2;
   localparam int CSR_DATA_W   = 16;

   // Divider: four lanes, four quotient bits produced per stage
   localparam int DIV_LANES    = 4;
   localparam int DIV_QBITS    = 32;
   localparam int DIV_PER      = 4;
   localparam int DIV_STAGES   = DIV_QBITS / DIV_PER;
   localparam int QUO_W        = DIV_QBITS + 1;

   // CORDIC: two lanes, sixteen iterations, two per stage
   localparam int COR_ITERS    = 16;
   localparam int COR_PER      = 2;
   localparam int COR_STAGES   = COR_ITERS / COR_PER;
   localparam int COR_W        = 33;
   localparam logic signed [COR_W-1:0] COR_K = 33'sd652032874;

   // Stage map
   localparam int DIV_FIRST    = 1;
   localparam int DIV_LAST     = DIV_FIRST + DIV_STAGES - 1;
   localparam int ST_PREP      = DIV_LAST + 1;
   localparam int COR_FIRST    = ST_PREP + 1;
   localparam int COR_LAST     = COR_FIRST + COR_STAGES - 1;
   localparam int ST_RND       = COR_LAST + 1;
   localparam int ST_MUL       = ST_RND + 1;
   localparam int ST_OUT       = ST_MUL + 1;
   localparam int NST          = ST_OUT + 1;

   localparam logic [BAND_W-1:0] MAX_BANDS_V = BAND_W'(MAX_BANDS);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_LAT_BANDS  = 2'd0,
      CSR_LONG_BANDS = 2'd1,
      CSR_RADIUS     = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic               quad_valid;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] second_index;
      logic [Q15_W-1:0]   tex_u;
      logic [Q15_W-1:0]   tex_v;
   } side_type;

   localparam logic signed [COR_W-1:0] ATAN_TAB [COR_ITERS] = '{
      33'sh020000000, 33'sh012E4051E, 33'sh009FB385B, 33'sh0051111D4,
      33'sh0028B0D43, 33'sh00145D7E1, 33'sh000A2F61E, 33'sh000517C55,
      33'sh00028BE53, 33'sh000145F2F, 33'sh0000A2F98, 33'sh0000517CC,
      33'sh000028BE6, 33'sh0000145F3, 33'sh00000A2FA, 33'sh00000517D
   };

   function automatic logic [BAND_W-1:0] eff_bands(input logic [BAND_W-1:0] r);
      logic [BAND_W-1:0] e;
      if (r == '0) begin
         e = BAND_W'(1);
      end else if (r > MAX_BANDS_V) begin
         e = MAX_BANDS_V;
      end else begin
         e = r;
      end
      return e;
   endfunction

   function automatic logic [Q15_W-1:0] sat_q15(input logic signed [33:0] v);
      logic [Q15_W-1:0] s;
      if (v > 34'sd32767) begin
         s = 16'h7FFF;
      end else if (v < -34'sd32768) begin
         s = 16'h8000;
      end else begin
         s = v[Q15_W-1:0];
      end
      return s;
   endfunction

   function automatic logic [POS_W-1:0] sat_p24(input logic signed [33:0] v);
      logic [POS_W-1:0] s;
      if (v > 34'sd8388607) begin
         s = 24'h7FFFFF;
      end else if (v < -34'sd8388608) begin
         s = 24'h800000;
      end else begin
         s = v[POS_W-1:0];
      end
      return s;
   endfunction

endpackage

// ===== rtl/uvs_req_if.sv =====
// Input channel interface: one grid point per transfer.
interface uvs_req_if;
   import uvs_pkg::*;
   logic              valid;
   logic              ready;
   logic [BAND_W-1:0] lat_index;
   logic [BAND_W-1:0] lon_index;

   modport source (output valid, output lat_index, output lon_index, input ready);
   modport sink   (input valid, input lat_index, input lon_index, output ready);
endinterface

// ===== rtl/uvs_rsp_if.sv =====
// Result channel interface: one vertex per transfer.
interface uvs_rsp_if;
   import uvs_pkg::*;
   logic               valid;
   logic               ready;
   logic [Q15_W-1:0]   normal_x;
   logic [Q15_W-1:0]   normal_y;
   logic [Q15_W-1:0]   normal_z;
   logic [POS_W-1:0]   pos_x;
   logic [POS_W-1:0]   pos_y;
   logic [POS_W-1:0]   pos_z;
   logic [Q15_W-1:0]   tex_u;
   logic [Q15_W-1:0]   tex_v;
   logic               quad_valid;
   logic [INDEX_W-1:0] first_index;
   logic [INDEX_W-1:0] second_index;

   modport source (output valid, output normal_x, output normal_y, output normal_z,
                   output pos_x, output pos_y, output pos_z, output tex_u, output tex_v,
                   output quad_valid, output first_index, output second_index,
                   input ready);
   modport sink   (input valid, input normal_x, input normal_y, input normal_z,
                   input pos_x, input pos_y, input pos_z, input tex_u, input tex_v,
                   input quad_valid, input first_index, input second_index,
                   output ready);
endinterface

// ===== rtl/uv_sphere_vertex_generator_core.sv =====
// UV-sphere vertex generator: 21-stage pipeline, one grid point accepted per cycle.
// A grid point (lat_index, lon_index) yields one vertex; a new point is taken every
// cycle while the result side keeps up. The pipeline holds the index clamp stage, the
// angle divider (four quotient bits per stage over eight stages), a prep stage, the
// CORDIC (two iterations per stage over eight stages) and the rounding, normal product
// and radius scaling stages. Each stage holds its item only while the one after it is
// full, so a stalled result side fills the pipeline before ready drops. Band and radius
// registers must only be written while the pipeline is empty.
module uv_sphere_vertex_generator_core (
   input  logic                           clock,
   input  logic                           reset,
   uvs_req_if.sink                        req_if,
   uvs_rsp_if.source                      rsp_if,
   input  logic                           csr_we,
   input  logic [uvs_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [uvs_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import uvs_pkg::*;

   // Configuration registers
   logic [BAND_W-1:0]   lat_bands_ff, long_bands_ff;
   logic [RADIUS_W-1:0] radius_ff;
   logic [BAND_W-1:0]   lb, gb;

   always_ff @(posedge clock) begin
      if (reset) begin
         lat_bands_ff  <= BAND_W'(16);
         long_bands_ff <= BAND_W'(16);
         radius_ff     <= RADIUS_W'(256);
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_LAT_BANDS:  lat_bands_ff  <= csr_wdata[BAND_W-1:0];
            CSR_LONG_BANDS: long_bands_ff <= csr_wdata[BAND_W-1:0];
            CSR_RADIUS:     radius_ff     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign lb = eff_bands(lat_bands_ff);
   assign gb = eff_bands(long_bands_ff);

   // Stage valids and per-stage advance
   logic [NST-1:0] v_ff, en;

   always_comb begin
      en[NST-1] = !v_ff[NST-1] || rsp_if.ready;
      for (int k = NST - 2; k >= 0; k--) begin
         en[k] = !v_ff[k] || en[k+1];
      end
   end

   assign req_if.ready = en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else begin
         if (en[0]) v_ff[0] <= req_if.valid;
         for (int k = 1; k < NST; k++) begin
            if (en[k]) v_ff[k] <= v_ff[k-1];
         end
      end
   end

   // Stage 0: clamp indices on transfer
   logic [BAND_W-1:0] lat0_ff, lon0_ff;

   always_ff @(posedge clock) begin
      if (en[0]) begin
         lat0_ff <= (req_if.lat_index > lb) ? lb : req_if.lat_index;
         lon0_ff <= (req_if.lon_index > gb) ? gb : req_if.lon_index;
      end
   end

   // Divider lane set-up and vertex indices
   logic [BAND_W-1:0] num0 [DIV_LANES];
   logic [BAND_W-1:0] dvs  [DIV_LANES];
   side_type          side0;
   side_type          side_ff [DIV_FIRST:NST-1];

   always_comb begin
      logic [18:0] prod;
      logic [18:0] first;
      prod     = 19'(lat0_ff) * 19'({1'b0, gb} + 10'd1);
      first    = prod + 19'(lon0_ff);
      num0[0]  = lat0_ff;
      num0[1]  = lon0_ff;
      num0[2]  = lb - lat0_ff;
      num0[3]  = gb - lon0_ff;
      dvs[0]   = lb;
      dvs[1]   = gb;
      dvs[2]   = lb;
      dvs[3]   = gb;
      side0.quad_valid = (lat0_ff < lb) && (lon0_ff < gb);
      side0.first_index  = side0.quad_valid ? first[INDEX_W-1:0] : '0;
      side0.second_index = side0.quad_valid ?
                           INDEX_W'(first + 19'(gb) + 19'd1) : '0;
      side0.tex_u = '0;
      side0.tex_v = '0;
   end

   // Divider stages: floor(n * 2^32 / d) for n <= d
   logic [BAND_W-1:0] rem_ff [DIV_FIRST:DIV_LAST][DIV_LANES];
   logic [QUO_W-1:0]  quo_ff [DIV_FIRST:DIV_LAST][DIV_LANES];

   for (genvar k = DIV_FIRST; k <= DIV_LAST; k++) begin : g_div
      for (genvar l = 0; l < DIV_LANES; l++) begin : g_lane
         logic [BAND_W-1:0] rem_in, rem_start;
         logic [QUO_W-1:0]  quo_in, quo_start;

         // Seed from the operands in the first stage, else take the previous stage
         if (k == DIV_FIRST) begin : g_head
            assign quo_start = (num0[l] == dvs[l]) ? QUO_W'(1) : '0;
            assign rem_start = (num0[l] == dvs[l]) ? '0 : num0[l];
         end else begin : g_body
            assign quo_start = quo_ff[k-1][l];
            assign rem_start = rem_ff[k-1][l];
         end

         always_comb begin
            logic [BAND_W-1:0] r;
            logic [BAND_W:0]   r2;
            logic [QUO_W-1:0]  q;
            q = quo_start;
            r = rem_start;
            for (int j = 0; j < DIV_PER; j++) begin
               r2 = {r, 1'b0};
               if (r2 >= {1'b0, dvs[l]}) begin
                  r2 = r2 - {1'b0, dvs[l]};
                  q  = {q[QUO_W-2:0], 1'b1};
               end else begin
                  q  = {q[QUO_W-2:0], 1'b0};
               end
               r = r2[BAND_W-1:0];
            end
            rem_in = r;
            quo_in = q;
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               rem_ff[k][l] <= rem_in;
               quo_ff[k][l] <= quo_in;
            end
         end
      end

      // Advance the side fields with the quotient
      if (k == DIV_FIRST) begin : g_side_head
         always_ff @(posedge clock) begin
            if (en[k]) side_ff[k] <= side0;
         end
      end else begin : g_side_body
         always_ff @(posedge clock) begin
            if (en[k]) side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // Prep: angles, quadrant fold, CORDIC start; texture rounding
   logic signed [COR_W-1:0] cx_ff [ST_PREP:COR_LAST][2];
   logic signed [COR_W-1:0] cy_ff [ST_PREP:COR_LAST][2];
   logic signed [COR_W-1:0] cz_ff [ST_PREP:COR_LAST][2];
   logic                    flip_ff [ST_PREP:COR_LAST][2];

   always_ff @(posedge clock) begin
      logic [31:0] ang;
      logic [31:0] a2;
      logic        fl;
      logic [17:0] tu, tv;
      side_type    sd;
      if (en[ST_PREP]) begin
         for (int l = 0; l < 2; l++) begin
            ang = (l == 0) ? quo_ff[DIV_LAST][0][32:1] : quo_ff[DIV_LAST][1][31:0];
            fl  = (ang - 32'h4000_0000) < 32'h8000_0000;
            a2  = fl ? (ang - 32'h8000_0000) : ang;
            cx_ff[ST_PREP][l]   <= COR_K;
            cy_ff[ST_PREP][l]   <= '0;
            cz_ff[ST_PREP][l]   <= {a2[31], a2};
            flip_ff[ST_PREP][l] <= fl;
         end
         tv = {1'b0, quo_ff[DIV_LAST][2][32:16]} + 18'd1;
         tu = {1'b0, quo_ff[DIV_LAST][3][32:16]} + 18'd1;
         sd       = side_ff[DIV_LAST];
         sd.tex_v = tv[16:1];
         sd.tex_u = tu[16:1];
         side_ff[ST_PREP] <= sd;
      end
   end

   // CORDIC stages, rotation mode
   for (genvar k = COR_FIRST; k <= COR_LAST; k++) begin : g_cor
      for (genvar l = 0; l < 2; l++) begin : g_lane
         logic signed [COR_W-1:0] x_in, y_in, z_in;

         always_comb begin
            logic signed [COR_W-1:0] x, y, z, dx, dy;
            x = cx_ff[k-1][l];
            y = cy_ff[k-1][l];
            z = cz_ff[k-1][l];
            for (int j = 0; j < COR_PER; j++) begin
               dx = y >>> ((k - COR_FIRST) * COR_PER + j);
               dy = x >>> ((k - COR_FIRST) * COR_PER + j);
               if (z >= 0) begin
                  x = x - dx;
                  y = y + dy;
                  z = z - ATAN_TAB[(k - COR_FIRST) * COR_PER + j];
               end else begin
                  x = x + dx;
                  y = y - dy;
                  z = z + ATAN_TAB[(k - COR_FIRST) * COR_PER + j];
               end
            end
            x_in = x;
            y_in = y;
            z_in = z;
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               cx_ff[k][l]   <= x_in;
               cy_ff[k][l]   <= y_in;
               cz_ff[k][l]   <= z_in;
               flip_ff[k][l] <= flip_ff[k-1][l];
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en[k]) side_ff[k] <= side_ff[k-1];
      end
   end

   // Round: undo the fold, round half up to Q1.15 and saturate
   logic [Q15_W-1:0] sin_ff [2];
   logic [Q15_W-1:0] cos_ff [2];

   always_ff @(posedge clock) begin
      logic signed [33:0] xs, ys;
      if (en[ST_RND]) begin
         for (int l = 0; l < 2; l++) begin
            xs = flip_ff[COR_LAST][l] ? -34'(cx_ff[COR_LAST][l]) : 34'(cx_ff[COR_LAST][l]);
            ys = flip_ff[COR_LAST][l] ? -34'(cy_ff[COR_LAST][l]) : 34'(cy_ff[COR_LAST][l]);
            cos_ff[l] <= sat_q15((xs + 34'sd16384) >>> 15);
            sin_ff[l] <= sat_q15((ys + 34'sd16384) >>> 15);
         end
         side_ff[ST_RND] <= side_ff[COR_LAST];
      end
   end

   // Normal products
   logic [Q15_W-1:0] nx_ff, ny_ff, nz_ff;

   always_ff @(posedge clock) begin
      logic signed [31:0] px, pz;
      if (en[ST_MUL]) begin
         px    = $signed(cos_ff[1]) * $signed(sin_ff[0]);
         pz    = $signed(sin_ff[1]) * $signed(sin_ff[0]);
         nx_ff <= sat_q15((34'(px) + 34'sd16384) >>> 15);
         nz_ff <= sat_q15((34'(pz) + 34'sd16384) >>> 15);
         ny_ff <= cos_ff[0];
         side_ff[ST_MUL] <= side_ff[ST_RND];
      end
   end

   // Output register: radius scaling
   logic [Q15_W-1:0] onx_ff, ony_ff, onz_ff;
   logic [POS_W-1:0] px_ff, py_ff, pz_ff;

   always_ff @(posedge clock) begin
      logic signed [16:0] r;
      logic signed [32:0] sx, sy, sz;
      if (en[ST_OUT]) begin
         r  = $signed({1'b0, radius_ff});
         sx = r * $signed(nx_ff);
         sy = r * $signed(ny_ff);
         sz = r * $signed(nz_ff);
         px_ff  <= sat_p24((34'(sx) + 34'sd128) >>> 8);
         py_ff  <= sat_p24((34'(sy) + 34'sd128) >>> 8);
         pz_ff  <= sat_p24((34'(sz) + 34'sd128) >>> 8);
         onx_ff <= nx_ff;
         ony_ff <= ny_ff;
         onz_ff <= nz_ff;
         side_ff[ST_OUT] <= side_ff[ST_MUL];
      end
   end

   assign rsp_if.valid        = v_ff[ST_OUT];
   assign rsp_if.normal_x     = onx_ff;
   assign rsp_if.normal_y     = ony_ff;
   assign rsp_if.normal_z     = onz_ff;
   assign rsp_if.pos_x        = px_ff;
   assign rsp_if.pos_y        = py_ff;
   assign rsp_if.pos_z        = pz_ff;
   assign rsp_if.tex_u        = side_ff[ST_OUT].tex_u;
   assign rsp_if.tex_v        = side_ff[ST_OUT].tex_v;
   assign rsp_if.quad_valid   = side_ff[ST_OUT].quad_valid;
   assign rsp_if.first_index  = side_ff[ST_OUT].first_index;
   assign rsp_if.second_index = side_ff[ST_OUT].second_index;

`ifndef SYNTHESIS
   a_ready_when_out_empty: assert property (@(posedge clock) disable iff (reset)
      !v_ff[ST_OUT] |-> req_if.ready)
      else $error("input stalled with empty output stage");
   a_no_quad_zero_index: assert property (@(posedge clock) disable iff (reset)
      (rsp_if.valid && !rsp_if.quad_valid) |->
         (rsp_if.first_index == '0 && rsp_if.second_index == '0))
      else $error("vertex indices set without a quad");
   a_tex_range: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid |-> (rsp_if.tex_u <= 16'h8000 && rsp_if.tex_v <= 16'h8000))
      else $error("texture coordinate above one");
`endif

endmodule

// ===== test/tb_uv_sphere_vertex_generator_core.sv =====
// Self-checking testbench for the UV-sphere vertex generator core.
`timescale 1ns / 100ps

module tb_uv_sphere_vertex_generator_core;
   import uvs_pkg::*;

   localparam logic [CSR_INDEX_W-1:0] CSR_SPARE = 2'd3;
   localparam int DRAIN_CYCLES = 40;

   typedef struct packed {
      logic [Q15_W-1:0]   normal_x;
      logic [Q15_W-1:0]   normal_y;
      logic [Q15_W-1:0]   normal_z;
      logic [POS_W-1:0]   pos_x;
      logic [POS_W-1:0]   pos_y;
      logic [POS_W-1:0]   pos_z;
      logic [Q15_W-1:0]   tex_u;
      logic [Q15_W-1:0]   tex_v;
      logic               quad_valid;
      logic [INDEX_W-1:0] first_index;
      logic [INDEX_W-1:0] second_index;
   } vertex_type;

   // Vertex predictor and queue of expected vertices
   class vertex_scoreboard;
      logic [BAND_W-1:0]   lat_reg;
      logic [BAND_W-1:0]   long_reg;
      logic [RADIUS_W-1:0] radius_reg;
      vertex_type          pending[$];
      int                  errors;
      longint              arctan[16] = '{
         64'h20000000, 64'h12E4051E, 64'h09FB385B, 64'h051111D4,
         64'h028B0D43, 64'h0145D7E1, 64'h00A2F61E, 64'h00517C55,
         64'h0028BE53, 64'h00145F2F, 64'h000A2F98, 64'h000517CC,
         64'h00028BE6, 64'h000145F3, 64'h0000A2FA, 64'h0000517D};

      function new();
         lat_reg = 16;
         long_reg = 16;
         radius_reg = 256;
         errors = 0;
      endfunction

      function void write_reg(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
         case (idx)
            CSR_LAT_BANDS:  lat_reg = val[BAND_W-1:0];
            CSR_LONG_BANDS: long_reg = val[BAND_W-1:0];
            CSR_RADIUS:     radius_reg = val;
            default: ;
         endcase
      endfunction

      function longint clamp(longint v, longint lo, longint hi);
         return v < lo ? lo : (v > hi ? hi : v);
      endfunction

      function longint bands_used(longint r);
         return r == 0 ? 1 : (r > MAX_BANDS ? MAX_BANDS : r);
      endfunction

      // Quadrant fold, then 16 rotations at scale 2^30
      function void sin_cos(logic [31:0] ang, output longint s, output longint c);
         logic [31:0] shifted;
         logic        fold;
         longint      x, y, z, dx, dy;
         shifted = ang - 32'h4000_0000;
         fold = shifted < 32'h8000_0000;
         if (fold) ang = ang - 32'h8000_0000;
         z = longint'($signed(ang));
         x = 652032874;
         y = 0;
         for (int i = 0; i < 16; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            if (z >= 0) begin
               x -= dx; y += dy; z -= arctan[i];
            end else begin
               x += dx; y -= dy; z += arctan[i];
            end
         end
         if (fold) begin
            x = -x; y = -y;
         end
         c = clamp((x + 16384) >>> 15, -32768, 32767);
         s = clamp((y + 16384) >>> 15, -32768, 32767);
      endfunction

      function longint q15_product(longint a, longint b);
         return clamp((a * b + 16384) >>> 15, -32768, 32767);
      endfunction

      function longint radius_scale(longint n);
         return clamp((longint'(radius_reg) * n + 128) >>> 8, -8388608, 8388607);
      endfunction

      function vertex_type predict(logic [BAND_W-1:0] lat_in, logic [BAND_W-1:0] lon_in);
         vertex_type v;
         longint     lb, gb, lat, lon, st, ct, sp, cp, nx, ny, nz, first;
         logic [63:0] th, ph;
         lb = bands_used(lat_reg);
         gb = bands_used(long_reg);
         lat = lat_in > lb ? lb : lat_in;
         lon = lon_in > gb ? gb : lon_in;
         th = (64'(lat) << 31) / 64'(lb);
         ph = (64'(lon) << 32) / 64'(gb);
         sin_cos(th[31:0], st, ct);
         sin_cos(ph[31:0], sp, cp);
         nx = q15_product(cp, st);
         ny = ct;
         nz = q15_product(sp, st);
         v.normal_x = nx[15:0];
         v.normal_y = ny[15:0];
         v.normal_z = nz[15:0];
         v.pos_x = 24'(radius_scale(nx));
         v.pos_y = 24'(radius_scale(ny));
         v.pos_z = 24'(radius_scale(nz));
         v.tex_u = 16'(((gb - lon) * 65536 + gb) / (2 * gb));
         v.tex_v = 16'(((lb - lat) * 65536 + lb) / (2 * lb));
         v.quad_valid = lat < lb && lon < gb;
         first = lat * (gb + 1) + lon;
         v.first_index = v.quad_valid ? 17'(first) : '0;
         v.second_index = v.quad_valid ? 17'(first + gb + 1) : '0;
         return v;
      endfunction

      function void note_point(logic [BAND_W-1:0] lat_in, logic [BAND_W-1:0] lon_in);
         pending.insert(pending.size(), predict(lat_in, lon_in));
      endfunction

      function void field(string name, longint e, longint a);
         if (e != a) begin
            errors++;
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, e, a);
         end
      endfunction

      function void check_vertex(vertex_type act);
         vertex_type e;
         if (pending.size() == 0) begin
            errors++;
            $display("%0t: unexpected vertex, expected none, actual %h", $time, act);
            return;
         end
         e = pending.pop_front();
         field("normal_x", e.normal_x, act.normal_x);
         field("normal_y", e.normal_y, act.normal_y);
         field("normal_z", e.normal_z, act.normal_z);
         field("pos_x", e.pos_x, act.pos_x);
         field("pos_y", e.pos_y, act.pos_y);
         field("pos_z", e.pos_z, act.pos_z);
         field("tex_u", e.tex_u, act.tex_u);
         field("tex_v", e.tex_v, act.tex_v);
         field("quad_valid", e.quad_valid, act.quad_valid);
         field("first_index", e.first_index, act.first_index);
         field("second_index", e.second_index, act.second_index);
      endfunction
   endclass

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_we = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = CSR_LAT_BANDS;
   logic [CSR_DATA_W-1:0]  csr_wdata = '0;

   uvs_req_if req_ch ();
   uvs_rsp_if rsp_ch ();

   vertex_scoreboard sb = new();

   uv_sphere_vertex_generator_core dut (
      .clock     (clock),
      .reset     (reset),
      .req_if    (req_ch),
      .rsp_if    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      req_ch.valid = 1'b0;
      req_ch.lat_index = '0;
      req_ch.lon_index = '0;
      rsp_ch.ready = 1'b0;
   end

   // Note accepted points, check accepted vertices
   always @(posedge clock) begin
      vertex_type act;
      if (!reset && req_ch.valid && req_ch.ready) begin
         sb.note_point(req_ch.lat_index, req_ch.lon_index);
      end
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         act = '{rsp_ch.normal_x, rsp_ch.normal_y, rsp_ch.normal_z, rsp_ch.pos_x,
                 rsp_ch.pos_y, rsp_ch.pos_z, rsp_ch.tex_u, rsp_ch.tex_v,
                 rsp_ch.quad_valid, rsp_ch.first_index, rsp_ch.second_index};
         sb.check_vertex(act);
      end
   end

   // Receiver stall pattern: free-running, random, or long stalls
   int ready_mode = 0;
   int ready_left = 0;
   always @(posedge clock) begin
      if (ready_left == 0) begin
         ready_mode <= $urandom_range(0, 2);
         ready_left <= $urandom_range(5, 60);
      end else begin
         ready_left <= ready_left - 1;
      end
      case (ready_mode)
         0: rsp_ch.ready <= 1'b1;
         1: rsp_ch.ready <= 1'($urandom_range(0, 1));
         default: rsp_ch.ready <= ($urandom_range(0, 7) == 0);
      endcase
   end

   int burst_left = 0;

   // Send one point; gaps fall between random bursts
   task automatic send_point(logic [BAND_W-1:0] lat, logic [BAND_W-1:0] lon);
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 30);
         if ($urandom_range(0, 2) != 0) begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
      burst_left--;
      req_ch.valid <= 1'b1;
      req_ch.lat_index <= lat;
      req_ch.lon_index <= lon;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold off until every vertex is back, then let the pipe drain
   task automatic drain();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (sb.pending.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_csr(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      sb.write_reg(idx, val);
      @(posedge clock);
   endtask

   task automatic set_sphere(logic [CSR_DATA_W-1:0] lat_b, logic [CSR_DATA_W-1:0] long_b,
                             logic [CSR_DATA_W-1:0] rad);
      write_csr(CSR_LAT_BANDS, lat_b);
      write_csr(CSR_LONG_BANDS, long_b);
      write_csr(CSR_RADIUS, rad);
      write_csr(CSR_SPARE, CSR_DATA_W'($urandom_range(0, 16'hFFFF)));
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly grid points inside the bands, some beyond them, some fully random
   task automatic random_points(int count);
      int lb, gb;
      lb = int'(sb.bands_used(sb.lat_reg));
      gb = int'(sb.bands_used(sb.long_reg));
      repeat (count) begin
         if ($urandom_range(0, 3) == 0)
            send_point(BAND_W'($urandom_range(0, 511)), BAND_W'($urandom_range(0, 511)));
         else
            send_point(BAND_W'($urandom_range(0, lb + 1 > 511 ? 511 : lb + 1)),
                       BAND_W'($urandom_range(0, gb + 1 > 511 ? 511 : gb + 1)));
      end
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] lb_r, gb_r;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed points under the reset sphere: poles, seam, beyond the bands
      send_point(0, 0);
      send_point(16, 0);
      send_point(8, 0);
      send_point(8, 4);
      send_point(8, 8);
      send_point(8, 12);
      send_point(4, 16);
      send_point(15, 15);
      send_point(17, 3);
      send_point(3, 40);
      send_point(9'h1FF, 9'h1FF);
      send_point(9'h155, 9'h0AA);
      send_point(9'h0AA, 9'h155);
      drain();

      // Extremes: one band and full radius, then largest grid and zero radius
      set_sphere(1, 1, 16'hFFFF);
      send_point(0, 0);
      send_point(1, 0);
      send_point(0, 1);
      send_point(2, 300);
      random_points(60);
      drain();
      set_sphere(256, 256, 0);
      send_point(255, 255);
      send_point(256, 256);
      send_point(128, 64);
      random_points(100);
      drain();
      set_sphere(0, 16'h01FF, 16'h8000);
      send_point(0, 100);
      send_point(1, 300);
      random_points(100);
      drain();
      set_sphere(16'hFE03, 16'h0105, 16'h7FFF);
      random_points(100);
      drain();

      // Random spheres, mostly small band counts
      repeat (6) begin
         lb_r = ($urandom_range(0, 4) == 0) ? CSR_DATA_W'($urandom_range(0, 16'hFFFF))
                                            : CSR_DATA_W'($urandom_range(1, 40));
         gb_r = ($urandom_range(0, 4) == 0) ? CSR_DATA_W'($urandom_range(0, 16'hFFFF))
                                            : CSR_DATA_W'($urandom_range(1, 40));
         set_sphere(lb_r, gb_r, CSR_DATA_W'($urandom_range(0, 16'hFFFF)));
         random_points(120);
         drain();
      end

      if (sb.errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #5_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
